// ===== hw/rtl/multinomial_posterior_share_assert.svh =====
// Assertion macros shared by the RTL.
`ifndef MULTINOMIAL_POSTERIOR_SHARE_ASSERT_SVH
`define MULTINOMIAL_POSTERIOR_SHARE_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define MPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mps_pkg.sv =====
`timescale 1ns / 1ps
package mps_pkg;

    localparam int NUM_GROUPS     = 8;
    localparam int NUM_CANDIDATES = 8;

    localparam int GRP_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int CAND_W = (NUM_CANDIDATES > 1) ? $clog2(NUM_CANDIDATES) : 1;
    localparam int PROB_DEPTH = NUM_GROUPS * NUM_CANDIDATES;
    localparam int PROB_AW = (PROB_DEPTH > 1) ? $clog2(PROB_DEPTH) : 1;

    localparam int VAL_W   = 16;
    localparam int ACC_W   = 2 * VAL_W + 4;   // sum of up to 16 products
    localparam int DIFF_W  = ACC_W + 1;
    localparam int RATIO_W = 48;
    localparam int SUM_W   = 52;
    localparam int SHARE_W = 19;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 52;

    localparam logic [1:0] OP_LOAD_PROB  = 2'd0;
    localparam logic [1:0] OP_LOAD_COUNT = 2'd1;
    localparam logic [1:0] OP_LOAD_VOTES = 2'd2;
    localparam logic [1:0] OP_COMPUTE    = 2'd3;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hw/rtl/mps_ram.sv =====
`timescale 1ns / 1ps
module mps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== hw/rtl/mps_div.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
module mps_div
    import mps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  div_ctrl_t            ctrl,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output div_stat_t            stat,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

// ===== hw/rtl/multinomial_posterior_share.sv =====
`timescale 1ns / 1ps
// channel   ports                       moves
// s_        valid/ready, 4 fields       one load or compute transaction
// m_        valid/ready, 4 fields       one share per candidate, last on final
//
// A compute runs a ratio pass and then a share pass. Both are paced by the
// single radix-2 divider (64 steps) shared by both divisions, and the ratio
// pass also by the one-read-per-cycle probability RAM walked per group.
// Reset clears control and the ratio store; tables are undefined until loaded.
// s_ready is low for the whole compute; an m_ stall holds the sequencer.
`include "multinomial_posterior_share_assert.svh"
module multinomial_posterior_share
    import mps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [2:0]         s_group_index,
    input  logic [2:0]         s_candidate_index,
    input  logic [15:0]        s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [18:0] m_share,
    output logic [2:0]         m_group_out,
    output logic [2:0]         m_candidate_out,
    output logic               m_last
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_PADDR = 12'b000000000010,
        S_PMUL  = 12'b000000000100,
        S_GADDR = 12'b000000001000,
        S_GMUL  = 12'b000000010000,
        S_GACC  = 12'b000000100000,
        S_RDIV  = 12'b000001000000,
        S_RWAIT = 12'b000010000000,
        S_SDIV  = 12'b000100000000,
        S_SWAIT = 12'b001000000000,
        S_OUT   = 12'b010000000000,
        S_SPARE = 12'b100000000000
    } state_t;

    localparam logic [DIV_NUM_W-1:0] RATIO_MAG = DIV_NUM_W'(1) << (RATIO_W - 1);
    localparam logic [DIV_NUM_W-1:0] SHARE_MAG = DIV_NUM_W'(1) << (SHARE_W - 1);

    state_t state_reg, state_next;

    logic [VAL_W-1:0]   cnt_reg   [NUM_GROUPS];
    logic [VAL_W-1:0]   votes_reg [NUM_CANDIDATES];
    logic signed [RATIO_W-1:0] ratio_reg [NUM_CANDIDATES];
    logic signed [SUM_W-1:0]   sum_reg, sum_next;

    logic [GRP_W-1:0]   g_reg, g_next;
    logic [CAND_W-1:0]  c_reg, c_next;
    logic [GRP_W-1:0]   h_reg, h_next;
    logic [VAL_W-1:0]   p_reg, p_next;
    logic [2*VAL_W-1:0] pv_reg, pv_next;
    logic [2*VAL_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;

    logic signed [SHARE_W-1:0] share_reg, share_next;
    logic [2:0]         gout_reg, gout_next;
    logic [2:0]         cout_reg, cout_next;
    logic               last_reg, last_next;

    // shared multiplier
    logic [VAL_W-1:0]   mul_a, mul_b;
    logic [2*VAL_W-1:0] mul_p;

    logic                ram_we;
    logic [PROB_AW-1:0]  ram_waddr, ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;

    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_mag;
    logic signed [RATIO_W-1:0] ratio_cur, ratio_sat;
    logic [RATIO_W-1:0]       ratio_mag;
    logic [SUM_W-1:0]         sum_mag;
    logic                     accept;
    logic                     ratio_we;
    logic signed [RATIO_W-1:0] ratio_wdata;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_share = share_reg;
    assign m_group_out = gout_reg;
    assign m_candidate_out = cout_reg;
    assign m_last = last_reg;

    assign ram_we    = accept && (s_opcode == OP_LOAD_PROB)
                       && (32'(s_group_index) < NUM_GROUPS)
                       && (32'(s_candidate_index) < NUM_CANDIDATES);
    assign ram_waddr = PROB_AW'(32'(s_group_index) * NUM_CANDIDATES
                                + 32'(s_candidate_index));
    assign ram_raddr = (state_reg == S_PADDR)
                       ? PROB_AW'(32'(g_reg) * NUM_CANDIDATES + 32'(c_reg))
                       : PROB_AW'(32'(h_reg) * NUM_CANDIDATES + 32'(c_reg));

    mps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (PROB_DEPTH)
    ) u_prob_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    always_comb begin
        mul_a = ram_rdata;
        mul_b = (state_reg == S_PMUL) ? votes_reg[c_reg] : cnt_reg[h_reg];
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        diff      = $signed({1'b0, acc_reg}) - $signed(DIFF_W'(p_reg));
        diff_mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        ratio_cur = ratio_reg[c_reg];
        ratio_mag = ratio_cur[RATIO_W-1] ? RATIO_W'(-ratio_cur) : RATIO_W'(ratio_cur);
        sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        if (neg_reg) begin
            ratio_sat = (div_quot >= RATIO_MAG) ? {1'b1, {(RATIO_W-1){1'b0}}}
                                                : -$signed(div_quot[RATIO_W-1:0]);
        end else begin
            ratio_sat = (div_quot >= RATIO_MAG) ? {1'b0, {(RATIO_W-1){1'b1}}}
                                                : $signed(div_quot[RATIO_W-1:0]);
        end
    end

    always_comb begin
        state_next  = state_reg;
        g_next      = g_reg;
        c_next      = c_reg;
        h_next      = h_reg;
        p_next      = p_reg;
        pv_next     = pv_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        sum_next    = sum_reg;
        share_next  = share_reg;
        gout_next   = gout_reg;
        cout_next   = cout_reg;
        last_next   = last_reg;
        div_ctrl    = '0;
        div_num     = '0;
        div_den     = '0;
        ratio_we    = 1'b0;
        ratio_wdata = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_opcode == OP_COMPUTE)
                    && (32'(s_group_index) < NUM_GROUPS)) begin
                    g_next     = GRP_W'(s_group_index);
                    c_next     = '0;
                    sum_next   = '0;
                    state_next = S_PADDR;
                end
            end
            S_PADDR: state_next = S_PMUL;
            S_PMUL: begin
                p_next     = ram_rdata;
                pv_next    = mul_p;
                h_next     = '0;
                acc_next   = '0;
                state_next = S_GADDR;
            end
            S_GADDR: state_next = S_GMUL;
            S_GMUL: begin
                prod_next  = mul_p;
                state_next = S_GACC;
            end
            S_GACC: begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (h_reg == GRP_W'(NUM_GROUPS - 1)) begin
                    state_next = S_RDIV;
                end else begin
                    h_next     = h_reg + 1'b1;
                    state_next = S_GADDR;
                end
            end
            S_RDIV: begin
                if (diff == '0) begin
                    // zero difference: ratio is zero
                    ratio_we    = 1'b1;
                    ratio_wdata = '0;
                    if (c_reg == CAND_W'(NUM_CANDIDATES - 1)) begin
                        c_next     = '0;
                        state_next = S_SDIV;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_PADDR;
                    end
                end else begin
                    div_ctrl.start = 1'b1;
                    div_num  = DIV_NUM_W'({pv_reg, 16'b0});
                    div_den  = DIV_DEN_W'(diff_mag);
                    neg_next = diff[DIFF_W-1];
                    state_next = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (div_stat.done) begin
                    ratio_we    = 1'b1;
                    ratio_wdata = ratio_sat;
                    sum_next    = sum_reg + SUM_W'(ratio_sat);
                    if (c_reg == CAND_W'(NUM_CANDIDATES - 1)) begin
                        c_next     = '0;
                        state_next = S_SDIV;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_PADDR;
                    end
                end
            end
            S_SDIV: begin
                gout_next = 3'(g_reg);
                cout_next = 3'(c_reg);
                last_next = (c_reg == CAND_W'(NUM_CANDIDATES - 1));
                if ((sum_reg == '0) || (ratio_cur == '0)) begin
                    share_next = '0;
                    state_next = S_OUT;
                end else begin
                    div_ctrl.start = 1'b1;
                    div_num  = {ratio_mag, 16'b0};
                    div_den  = DIV_DEN_W'(sum_mag);
                    neg_next = ratio_cur[RATIO_W-1] ^ sum_reg[SUM_W-1];
                    state_next = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (div_stat.done) begin
                    if (neg_reg) begin
                        share_next = (div_quot >= SHARE_MAG)
                                     ? {1'b1, {(SHARE_W-1){1'b0}}}
                                     : -$signed(div_quot[SHARE_W-1:0]);
                    end else begin
                        share_next = (div_quot >= SHARE_MAG)
                                     ? {1'b0, {(SHARE_W-1){1'b1}}}
                                     : $signed(div_quot[SHARE_W-1:0]);
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    if (c_reg == CAND_W'(NUM_CANDIDATES - 1)) begin
                        state_next = S_IDLE;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_SDIV;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            c_reg     <= '0;
            h_reg     <= '0;
            sum_reg   <= '0;
            for (int i = 0; i < NUM_CANDIDATES; i++) begin
                ratio_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            c_reg     <= c_next;
            h_reg     <= h_next;
            sum_reg   <= sum_next;
            if (ratio_we) begin
                ratio_reg[c_reg] <= ratio_wdata;
            end
        end
        g_reg     <= g_next;
        p_reg     <= p_next;
        pv_reg    <= pv_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        share_reg <= share_next;
        gout_reg  <= gout_next;
        cout_reg  <= cout_next;
        last_reg  <= last_next;
        if (accept && (s_opcode == OP_LOAD_COUNT) && (32'(s_group_index) < NUM_GROUPS)) begin
            cnt_reg[GRP_W'(s_group_index)] <= s_value;
        end
        if (accept && (s_opcode == OP_LOAD_VOTES)
            && (32'(s_candidate_index) < NUM_CANDIDATES)) begin
            votes_reg[CAND_W'(s_candidate_index)] <= s_value;
        end
    end

    `MPS_ASSERT_IMP(a_out_blocks_in, m_valid, !s_ready, "input taken while a share is pending")
    `MPS_ASSERT_IMP(a_div_idle_start, div_ctrl.start, !div_stat.busy, "divider restarted while busy")
    `MPS_ASSERT_IMP(a_last_final, m_valid && m_last,
        m_candidate_out == 3'(NUM_CANDIDATES - 1), "last flag on a non-final candidate")
    `MPS_ASSERT_NXT(a_last_frees, m_valid && m_ready && m_last, s_ready,
        "not ready after final share")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import mps_pkg::*;

    typedef struct {
        logic signed [18:0] share;
        logic [2:0]         grp;
        logic [2:0]         cand;
        logic               last;
    } share_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode = OP_LOAD_PROB;
    logic [2:0]         s_group_index = '0;
    logic [2:0]         s_candidate_index = '0;
    logic [15:0]        s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [18:0] m_share;
    logic [2:0]         m_group_out;
    logic [2:0]         m_candidate_out;
    logic               m_last;

    // shadow of the ballot box tables
    logic [15:0] prob_tbl [NUM_GROUPS][NUM_CANDIDATES];
    logic [15:0] count_tbl [NUM_GROUPS];
    logic [15:0] votes_tbl [NUM_CANDIDATES];

    share_t expected_shares [$];
    int     mismatches = 0;
    bit     no_idle = 1'b0;

    multinomial_posterior_share DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_group_index(s_group_index),
        .s_candidate_index(s_candidate_index), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_share(m_share), .m_group_out(m_group_out),
        .m_candidate_out(m_candidate_out), .m_last(m_last)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2400000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint unsigned mag(longint signed v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic void predict_shares(int g);
        longint signed          ratio [NUM_CANDIDATES];
        longint signed          total;
        longint signed          diff;
        longint signed          sh;
        longint unsigned        wsum, num, q, p;
        share_t                 e;
        total = 0;
        for (int c = 0; c < NUM_CANDIDATES; c++) begin
            wsum = 0;
            p = prob_tbl[g][c];
            for (int h = 0; h < NUM_GROUPS; h++)
                wsum += longint'(count_tbl[h]) * longint'(prob_tbl[h][c]);
            diff = longint'(wsum) - longint'(p);
            if (diff == 0) begin
                ratio[c] = 0;
            end else begin
                num = (p * longint'(votes_tbl[c])) << 16;
                q = num / mag(diff);
                if (diff < 0)
                    ratio[c] = (q >= 64'h8000_0000_0000) ? -64'sh8000_0000_0000 : -longint'(q);
                else
                    ratio[c] = (q > 64'h7FFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF : longint'(q);
            end
            total += ratio[c];
        end
        for (int c = 0; c < NUM_CANDIDATES; c++) begin
            if (total == 0 || ratio[c] == 0) begin
                sh = 0;
            end else begin
                q = (mag(ratio[c]) << 16) / mag(total);
                if ((ratio[c] < 0) != (total < 0))
                    sh = (q >= 262144) ? -262144 : -longint'(q);
                else
                    sh = (q > 262143) ? 262143 : longint'(q);
            end
            e.share = sh[18:0];
            e.grp   = g[2:0];
            e.cand  = c[2:0];
            e.last  = (c == NUM_CANDIDATES - 1);
            expected_shares.push_back(e);
        end
    endfunction

    // valid stays up from one transaction to the next unless an idle cycle is drawn
    task automatic send(logic [1:0] op, int g, int c, logic [15:0] v);
        bit hs;
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 23) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_opcode = op;
        s_group_index = g[2:0];
        s_candidate_index = c[2:0];
        s_value = v;
        forever begin
            #1;
            hs = s_ready;
            @(posedge aclk);
            if (hs) break;
            @(negedge aclk);
        end
        case (op)
            OP_LOAD_PROB:  prob_tbl[g][c] = v;
            OP_LOAD_COUNT: count_tbl[g] = v;
            OP_LOAD_VOTES: votes_tbl[c] = v;
            OP_COMPUTE:    predict_shares(g);
        endcase
    endtask

    // result checker
    always @(posedge aclk) begin
        share_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_shares.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected share transaction: share=%0d grp=%0d cand=%0d",
                             m_share, m_group_out, m_candidate_out);
            end else begin
                e = expected_shares.pop_front();
                if (m_share !== e.share || m_group_out !== e.grp ||
                    m_candidate_out !== e.cand || m_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp share=%0d grp=%0d cand=%0d last=%0d,",
                                  " got %0d %0d %0d %0d"},
                                 e.share, e.grp, e.cand, e.last,
                                 m_share, m_group_out, m_candidate_out, m_last);
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 23);
    end

    function automatic logic [15:0] rand_value();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(3));
            3: return 16'($urandom_range(255));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic load_box(logic [15:0] pv, logic [15:0] cv, logic [15:0] vv);
        for (int g = 0; g < NUM_GROUPS; g++)
            for (int c = 0; c < NUM_CANDIDATES; c++)
                send(OP_LOAD_PROB, g, c, pv);
        for (int g = 0; g < NUM_GROUPS; g++) send(OP_LOAD_COUNT, g, 0, cv);
        for (int c = 0; c < NUM_CANDIDATES; c++) send(OP_LOAD_VOTES, 0, c, vv);
    endtask

    // counts all zero: every difference is minus the probability
    task automatic test_negative_difference();
        load_box(16'h8000, 16'h0000, 16'h0010);
        send(OP_LOAD_PROB, 3, 5, 16'h0000);
        send(OP_LOAD_PROB, 3, 2, 16'h0001);
        send(OP_COMPUTE, 3, 0, 16'h0000);
    endtask

    // only the computed group has count one: differences and sum vanish
    task automatic test_zero_difference();
        send(OP_LOAD_COUNT, 6, 0, 16'h0001);
        send(OP_COMPUTE, 6, 0, 16'hFFFF);
    endtask

    // mixed-sign ratios give shares of both signs
    task automatic test_saturation();
        send(OP_LOAD_COUNT, 6, 0, 16'h0000);
        send(OP_LOAD_COUNT, 0, 0, 16'h0001);
        send(OP_LOAD_PROB, 0, 0, 16'h4000);
        send(OP_LOAD_PROB, 1, 0, 16'h2000);
        send(OP_LOAD_PROB, 0, 1, 16'h2000);
        send(OP_LOAD_PROB, 1, 1, 16'h4001);
        send(OP_COMPUTE, 1, 0, 16'h0000);
    endtask

    // full-scale counts and votes
    task automatic test_extremes();
        send(OP_LOAD_PROB, 0, 7, 16'hFFFF);
        for (int g = 0; g < NUM_GROUPS; g++) send(OP_LOAD_COUNT, g, 0, 16'hFFFF);
        for (int c = 0; c < NUM_CANDIDATES; c++) send(OP_LOAD_VOTES, 0, c, 16'hFFFF);
        send(OP_COMPUTE, 0, 7, 16'h0000);
        send(OP_LOAD_COUNT, 7, 0, 16'h0000);
        send(OP_LOAD_VOTES, 0, 7, 16'h0000);
        send(OP_COMPUTE, 7, 0, 16'hFFFF);
    endtask

    task automatic test_random();
        int r;
        for (int n = 0; n < 25; n++) begin
            no_idle = (n >= 8 && n < 20);
            r = $urandom_range(9);
            if (r < 2)
                send(OP_COMPUTE, $urandom_range(7), $urandom_range(7), 16'($urandom));
            else
                send(2'(r % 3), $urandom_range(7), $urandom_range(7), rand_value());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_negative_difference();
        test_zero_difference();
        test_saturation();
        test_extremes();
        test_random();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_shares.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
